>>> hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and operation codes for the MIPS subset executer.
// ----------------------------------------------------------------------------
package mse_pkg;

    // operation codes, dense list
    typedef enum logic [5:0] {
        CMD_ADD   = 6'd0,  CMD_ADDU  = 6'd1,  CMD_SUB  = 6'd2,  CMD_AND  = 6'd3,
        CMD_OR    = 6'd4,  CMD_XOR   = 6'd5,  CMD_NOR  = 6'd6,  CMD_NAND = 6'd7,
        CMD_SLT   = 6'd8,  CMD_SLL   = 6'd9,  CMD_SRL  = 6'd10, CMD_SRA  = 6'd11,
        CMD_JR    = 6'd12, CMD_ADDI  = 6'd13, CMD_ADDIU = 6'd14, CMD_LW  = 6'd15,
        CMD_LHU   = 6'd16, CMD_LH    = 6'd17, CMD_LB   = 6'd18, CMD_LBU  = 6'd19,
        CMD_SW    = 6'd20, CMD_SH    = 6'd21, CMD_SB   = 6'd22, CMD_LUI  = 6'd23,
        CMD_ANDI  = 6'd24, CMD_ORI   = 6'd25, CMD_NORI = 6'd26, CMD_SLTI = 6'd27,
        CMD_BEQ   = 6'd28, CMD_BNE   = 6'd29, CMD_BGTZ = 6'd30, CMD_J    = 6'd31,
        CMD_JAL   = 6'd32
    } t_cmd;

    // access size, coded as byte count minus one
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd3;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic [5:0]         cmd;
        logic [4:0]         src_reg;
        logic [4:0]         second_reg;
        logic [4:0]         dest_reg;
        logic [4:0]         shift_amount;
        logic signed [15:0] imm_value;
        logic [25:0]        jump_target;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  written_index;
        logic [31:0] written_value;
        logic        mem_write;
        logic        branch_taken;
    } t_out_item;

    // execute result handed from the alu to the top level
    typedef struct packed {
        logic [31:0] next_pc;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        taken;
        logic        is_load;
        logic        is_store;
        logic [1:0]  size;
        logic        ld_signed;
        logic [4:0]  ld_reg;
        logic [31:0] addr;
    } t_exec;

endpackage

>>> hw/rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mse_alu.sv
// ----------------------------------------------------------------------------
// mse_alu
// Execute logic: operand arithmetic, branch and jump targets, memory address.
// ----------------------------------------------------------------------------
module mse_alu
    import mse_pkg::*;
(
    input  t_in_item    i_item,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_pc,
    output t_exec       o_ex
);

    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] pc4;
    logic [31:0] branch_to;
    logic [31:0] jump_to;
    t_exec       ex;

    assign simm      = {{16{i_item.imm_value[15]}}, i_item.imm_value};
    assign zimm      = {16'd0, i_item.imm_value};
    assign pc4       = i_pc + 32'd4;
    assign branch_to = pc4 + {simm[29:0], 2'b00};
    assign jump_to   = {pc4[31:28], i_item.jump_target, 2'b00};

    // operation decode
    always_comb begin
        ex           = '0;
        ex.next_pc   = pc4;
        ex.addr      = i_a + simm;
        ex.ld_reg    = i_item.second_reg;
        case (i_item.cmd)
            CMD_ADD, CMD_ADDU: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = i_a + i_b;
            end
            CMD_SUB: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = i_a - i_b;
            end
            CMD_AND: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = i_a & i_b;
            end
            CMD_OR: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = i_a | i_b;
            end
            CMD_XOR: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = i_a ^ i_b;
            end
            CMD_NOR: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = ~(i_a | i_b);
            end
            CMD_NAND: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg; ex.wval = ~(i_a & i_b);
            end
            CMD_SLT: begin
                ex.wr   = 1'b1; ex.widx = i_item.dest_reg;
                ex.wval = {31'd0, $signed(i_a) < $signed(i_b)};
            end
            CMD_SLL: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg;
                ex.wval = i_b << i_item.shift_amount;
            end
            CMD_SRL: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg;
                ex.wval = i_b >> i_item.shift_amount;
            end
            CMD_SRA: begin
                ex.wr = 1'b1; ex.widx = i_item.dest_reg;
                ex.wval = $unsigned($signed(i_b) >>> i_item.shift_amount);
            end
            CMD_JR: begin
                ex.next_pc = i_a; ex.taken = 1'b1;
            end
            CMD_ADDI, CMD_ADDIU: begin
                ex.wr = 1'b1; ex.widx = i_item.second_reg; ex.wval = i_a + simm;
            end
            CMD_LW: begin
                ex.is_load = 1'b1; ex.size = SZ_WORD;
            end
            CMD_LHU: begin
                ex.is_load = 1'b1; ex.size = SZ_HALF;
            end
            CMD_LH: begin
                ex.is_load = 1'b1; ex.size = SZ_HALF; ex.ld_signed = 1'b1;
            end
            CMD_LB: begin
                ex.is_load = 1'b1; ex.size = SZ_BYTE; ex.ld_signed = 1'b1;
            end
            CMD_LBU: begin
                ex.is_load = 1'b1; ex.size = SZ_BYTE;
            end
            CMD_SW: begin
                ex.is_store = 1'b1; ex.size = SZ_WORD;
            end
            CMD_SH: begin
                ex.is_store = 1'b1; ex.size = SZ_HALF;
            end
            CMD_SB: begin
                ex.is_store = 1'b1; ex.size = SZ_BYTE;
            end
            CMD_LUI: begin
                ex.wr = 1'b1; ex.widx = i_item.second_reg; ex.wval = {zimm[15:0], 16'd0};
            end
            CMD_ANDI: begin
                ex.wr = 1'b1; ex.widx = i_item.second_reg; ex.wval = i_a & zimm;
            end
            CMD_ORI: begin
                ex.wr = 1'b1; ex.widx = i_item.second_reg; ex.wval = i_a | zimm;
            end
            CMD_NORI: begin
                ex.wr = 1'b1; ex.widx = i_item.second_reg; ex.wval = ~(i_a | zimm);
            end
            CMD_SLTI: begin
                ex.wr   = 1'b1; ex.widx = i_item.second_reg;
                ex.wval = {31'd0, $signed(i_a) < $signed(simm)};
            end
            CMD_BEQ: begin
                if (i_a == i_b) begin
                    ex.next_pc = branch_to; ex.taken = 1'b1;
                end
            end
            CMD_BNE: begin
                if (i_a != i_b) begin
                    ex.next_pc = branch_to; ex.taken = 1'b1;
                end
            end
            CMD_BGTZ: begin
                if ($signed(i_a) > 32'sd0) begin
                    ex.next_pc = branch_to; ex.taken = 1'b1;
                end
            end
            CMD_J: begin
                ex.next_pc = jump_to; ex.taken = 1'b1;
            end
            CMD_JAL: begin
                ex.wr = 1'b1; ex.widx = LINK_REG; ex.wval = pc4;
                ex.next_pc = jump_to; ex.taken = 1'b1;
            end
            default: begin
                ex.next_pc = i_pc;
            end
        endcase
        // register zero is never written
        if (ex.widx == 5'd0) begin
            ex.wr   = 1'b0;
            ex.wval = '0;
        end
    end

    assign o_ex = ex;

endmodule

>>> hw/rtl/mips_subset_instruction_executer.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executer
// Executes one decoded MIPS subset instruction per transaction.
// ----------------------------------------------------------------------------
// One decoded instruction goes in per input transaction and one result comes
// out. Register reads are registered in two copies of the register file RAM,
// then the instruction executes and commits; non-load instructions can be
// taken every cycle while the output is not stalled. Loads then read four
// byte-lane data RAMs into a second stage, and no instruction is taken while
// a load waits for its read. Register results are forwarded to the next
// instruction. After reset the data memory is cleared one row at a time,
// MEM_BYTES/4 rows in all, during which no instruction is taken; a config
// write (i_cfg_we) loads the PC from i_cfg_wdata. MEM_BYTES must be a power of two.
module mips_subset_instruction_executer
    import mse_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / 4;
    localparam int ROW_W  = ADDR_W - 2;

    // stage registers
    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        r_s1_fwd_a, r_s1_fwd_b;
    logic [31:0] r_s1_fwd_val;
    logic        r_s1_vld_a, r_s1_vld_b;
    logic        r_s2_valid;
    logic [4:0]  r_s2_reg;
    logic [1:0]  r_s2_lane0;
    logic [1:0]  r_s2_size;
    logic        r_s2_signed;
    logic [31:0] r_s2_pc;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [31:0] r_pc;
    logic [31:0] r_rvalid;
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    logic        out_free, s1_adv, s2_adv, accept;
    logic [31:0] rdata_a, rdata_b, op_a, op_b;
    t_exec       ex;
    logic        cm_we;
    logic [4:0]  cm_idx;
    logic [31:0] cm_val;
    logic [31:0] ld_val;
    logic [7:0]  ld_byte [4];
    logic [7:0]  bank_rdata [4];
    logic [ROW_W-1:0] lane_row [4];
    logic [7:0]       lane_byte [4];
    logic             lane_used [4];
    logic [1:0]       lane_j [4];
    logic [ADDR_W-1:0] lane_sum [4];

    // flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign s2_adv     = r_s2_valid && out_free;
    assign s1_adv     = r_s1_valid && !r_s2_valid && (ex.is_load || out_free);
    assign o_in_ready = !r_clr_busy
                      && (!r_s1_valid || (s1_adv && !ex.is_load))
                      && (!r_s2_valid || s2_adv);
    assign accept     = i_in_valid && o_in_ready;

    // register file, two read copies
    mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_idx), .i_wdata(cm_val),
        .i_re(accept), .i_raddr(i_in_data.src_reg), .o_rdata(rdata_a)
    );
    mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_idx), .i_wdata(cm_val),
        .i_re(accept), .i_raddr(i_in_data.second_reg), .o_rdata(rdata_b)
    );

    // operand select: forwarded write, stored value, or never-written zero
    assign op_a = r_s1_fwd_a ? r_s1_fwd_val : (r_s1_vld_a ? rdata_a : 32'd0);
    assign op_b = r_s1_fwd_b ? r_s1_fwd_val : (r_s1_vld_b ? rdata_b : 32'd0);

    mse_alu u_alu (
        .i_item(r_s1_item), .i_a(op_a), .i_b(op_b), .i_pc(r_pc), .o_ex(ex)
    );

    // byte lane mapping of a memory access
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lane_j[k]    = 2'(k) - ex.addr[1:0];
            lane_used[k] = (lane_j[k] <= ex.size);
            lane_sum[k]  = ex.addr[ADDR_W-1:0] + {{(ADDR_W-2){1'b0}}, lane_j[k]};
            lane_row[k]  = lane_sum[k][ADDR_W-1:2];
            lane_byte[k] = 8'(op_b >> {ex.size - lane_j[k], 3'b000});
        end
    end

    // data memory, one RAM per byte lane
    for (genvar k = 0; k < 4; k++) begin : g_bank
        mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (r_clr_busy || (s1_adv && ex.is_store && lane_used[k])),
            .i_waddr(r_clr_busy ? r_clr_row : lane_row[k]),
            .i_wdata(r_clr_busy ? 8'd0 : lane_byte[k]),
            .i_re   (s1_adv && ex.is_load),
            .i_raddr(lane_row[k]),
            .o_rdata(bank_rdata[k])
        );
    end

    // load data assembly
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ld_byte[i] = bank_rdata[2'(r_s2_lane0 + 2'(i))];
        end
        case (r_s2_size)
            SZ_BYTE: ld_val = {{24{r_s2_signed & ld_byte[0][7]}}, ld_byte[0]};
            SZ_HALF: ld_val = {{16{r_s2_signed & ld_byte[0][7]}}, ld_byte[0], ld_byte[1]};
            default: ld_val = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};
        endcase
    end

    // register write at commit
    always_comb begin
        cm_we  = 1'b0;
        cm_idx = ex.widx;
        cm_val = ex.wval;
        if (s2_adv) begin
            cm_we  = (r_s2_reg != 5'd0);
            cm_idx = r_s2_reg;
            cm_val = ld_val;
        end else if (s1_adv && !ex.is_load) begin
            cm_we = ex.wr;
        end
    end

    // next result
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (s2_adv) begin
            n_out_valid         = 1'b1;
            n_out.next_pc       = r_s2_pc;
            n_out.reg_write     = cm_we;
            n_out.written_index = cm_we ? r_s2_reg : 5'd0;
            n_out.written_value = cm_we ? ld_val : 32'd0;
            n_out.mem_write     = 1'b0;
            n_out.branch_taken  = 1'b0;
        end else if (s1_adv && !ex.is_load) begin
            n_out_valid         = 1'b1;
            n_out.next_pc       = ex.next_pc;
            n_out.reg_write     = ex.wr;
            n_out.written_index = ex.widx;
            n_out.written_value = ex.wval;
            n_out.mem_write     = ex.is_store;
            n_out.branch_taken  = ex.taken;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= 32'd0;
            r_rvalid    <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && ex.is_load) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (cm_we) begin
                r_rvalid[cm_idx] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end else if (s1_adv) begin
                r_pc <= ex.next_pc;
            end
            // clearing pass over the data memory rows
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_s1_item    <= i_in_data;
            r_s1_fwd_a   <= cm_we && (cm_idx == i_in_data.src_reg);
            r_s1_fwd_b   <= cm_we && (cm_idx == i_in_data.second_reg);
            r_s1_fwd_val <= cm_val;
            r_s1_vld_a   <= r_rvalid[i_in_data.src_reg];
            r_s1_vld_b   <= r_rvalid[i_in_data.second_reg];
        end
        if (s1_adv && ex.is_load) begin
            r_s2_reg    <= ex.ld_reg;
            r_s2_lane0  <= ex.addr[1:0];
            r_s2_size   <= ex.size;
            r_s2_signed <= ex.ld_signed;
            r_s2_pc     <= ex.next_pc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the MIPS subset executer, bound to the top level.
// ----------------------------------------------------------------------------
module mse_checker
    import mse_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // no register write means zero index and value
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.reg_write |->
            o_out_data.written_index == 5'd0 && o_out_data.written_value == 32'd0)
        else $error("write fields set without a register write");

    // register zero is never reported written
    a_no_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.reg_write |-> o_out_data.written_index != 5'd0)
        else $error("write to register zero reported");

    // a store neither writes a register nor redirects
    a_store_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.mem_write |->
            !o_out_data.reg_write && !o_out_data.branch_taken)
        else $error("store combined with other effects");

endmodule

bind mips_subset_instruction_executer mse_checker u_mse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
